[src/slcd_pkg.sv]
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types and constants for the length-prefixed frame deframer
// ----------------------------------------------------------------------------
package slcd_pkg;

   localparam logic [7:0] SYNC0_BYTE    = 8'hE0;
   localparam logic [7:0] SYNC1_BYTE    = 8'h0E;
   localparam logic [7:0] SYNC2_BYTE    = 8'h3A;
   localparam logic [7:0] TIMEOUT_RESET = 8'd10;

   // header bytes folded into the checksum
   localparam logic [7:0] HEADER_SUM = 8'(32'(SYNC0_BYTE) + 32'(SYNC1_BYTE) + 32'(SYNC2_BYTE));

   // request kinds carried in req_tuser
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_END_GOOD = 2'd1,
      KIND_END_BAD  = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      ST_HUNT     = 6'b000001,
      ST_SYNC1    = 6'b000010,
      ST_LEN_LO   = 6'b000100,
      ST_LEN_HI   = 6'b001000,
      ST_SYNC2    = 6'b010000,
      ST_PAYLOAD  = 6'b100000
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic        last;
   } result_type;

endpackage

[src/slcd_parser.sv]
// ----------------------------------------------------------------------------
// slcd_parser
// frame parse state, length and checksum tracking, timeout countdown
// ----------------------------------------------------------------------------
module slcd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 req_kind,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           timeout_ticks,
   output slcd_pkg::result_type result
);
   import slcd_pkg::*;

   parse_state_type state_ff, state_in;
   logic [15:0]     bytes_left_ff, bytes_left_in;
   logic [7:0]      running_sum_ff, running_sum_in;
   logic [15:0]     write_index_ff, write_index_in;
   logic [7:0]      timeout_left_ff, timeout_left_in;
   logic [7:0]      timeout_dec;
   logic            is_sync0;

   assign timeout_dec = timeout_left_ff - 8'd1;
   assign is_sync0    = (rx_byte == SYNC0_BYTE);

   always_comb begin
      state_in        = state_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      write_index_in  = write_index_ff;
      timeout_left_in = timeout_left_ff;
      result          = '0;
      result.kind     = KIND_PAYLOAD;

      if (req_accept) begin
         if (req_kind == REQ_TICK) begin
            if (state_ff != ST_HUNT) begin
               timeout_left_in = timeout_dec;
               if (timeout_dec == 8'd0) begin
                  state_in = ST_HUNT;
               end
            end
         end else begin
            unique case (state_ff)
               ST_HUNT: begin
                  if (is_sync0) begin
                     state_in        = ST_SYNC1;
                     timeout_left_in = timeout_ticks;
                  end
               end
               ST_SYNC1: begin
                  if (rx_byte == SYNC1_BYTE) begin
                     state_in = ST_LEN_LO;
                  end else if (is_sync0) begin
                     // mismatch byte retried as a new sync
                     state_in        = ST_SYNC1;
                     timeout_left_in = timeout_ticks;
                  end else begin
                     state_in = ST_HUNT;
                  end
               end
               ST_LEN_LO: begin
                  bytes_left_in  = {8'd0, rx_byte};
                  running_sum_in = rx_byte;
                  state_in       = ST_LEN_HI;
               end
               ST_LEN_HI: begin
                  bytes_left_in  = {rx_byte, bytes_left_ff[7:0]};
                  running_sum_in = running_sum_ff + rx_byte;
                  state_in       = ST_SYNC2;
               end
               ST_SYNC2: begin
                  if (rx_byte == SYNC2_BYTE) begin
                     state_in       = ST_PAYLOAD;
                     write_index_in = 16'd0;
                     running_sum_in = running_sum_ff + HEADER_SUM;
                  end else if (is_sync0) begin
                     state_in        = ST_SYNC1;
                     timeout_left_in = timeout_ticks;
                  end else begin
                     state_in = ST_HUNT;
                  end
               end
               ST_PAYLOAD: begin
                  result.valid = 1'b1;
                  result.data  = rx_byte;
                  result.index = write_index_ff;
                  if (bytes_left_ff > 16'd1) begin
                     bytes_left_in  = bytes_left_ff - 16'd1;
                     write_index_in = write_index_ff + 16'd1;
                     running_sum_in = running_sum_ff + rx_byte;
                     result.kind    = KIND_PAYLOAD;
                     result.last    = 1'b0;
                  end else begin
                     // checksum byte closes the frame
                     bytes_left_in = 16'd0;
                     state_in      = ST_HUNT;
                     result.kind   = (running_sum_ff == rx_byte) ? KIND_END_GOOD
                                                                  : KIND_END_BAD;
                     result.last   = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_HUNT;
         bytes_left_ff   <= '0;
         running_sum_ff  <= '0;
         write_index_ff  <= '0;
         timeout_left_ff <= '0;
      end else begin
         state_ff        <= state_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
         write_index_ff  <= write_index_in;
         timeout_left_ff <= timeout_left_in;
      end
   end

endmodule

[src/sync_length_checksum_deframer.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// deframes E0 0E len_lo len_hi 3A payload checksum frames from a byte stream
// ----------------------------------------------------------------------------
// Each request is either a received byte or a timer tick. The parser
// updates its frame state as the request is taken and the result lands in
// the output register on the same edge, so a new request is accepted every
// cycle as long as the output register is empty or being
// drained. Payload bytes come out with their position in the frame, and the
// checksum byte comes out as a frame-end result with tlast set and tuser
// flagging the additive checksum good or bad. The length field counts the
// checksum byte, and a length of zero acts as one. Ticks never produce a
// result; after a sync byte, timeout_ticks ticks abort the frame (zero means
// 256). The timeout register should only be written while no frame is in
// flight.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] req_type: 0 byte, 1 tick

   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] out_index
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast,   // last: frame end

   // timeout register
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import slcd_pkg::*;

   logic        timeout_ticks_ff;
   logic [7:0]  timeout_reg_ff;
   logic        req_accept;
   result_type  result;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic [15:0] rsp_index_ff;
   logic        rsp_last_ff;

   // take a request whenever the output slot is free or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // timeout register, written any time the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_reg_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_reg_ff <= csr_wr_data;
      end
   end

   // marks that the timeout register has been touched since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= 1'b0;
      end else if (csr_wr_en) begin
         timeout_ticks_ff <= 1'b1;
      end
   end

   slcd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_kind      (req_tuser[0]),
      .rx_byte       (req_tdata),
      .timeout_ticks (timeout_ticks_ff ? timeout_reg_ff : TIMEOUT_RESET),
      .result        (result)
   );

   // output register: loads on accept, clears when taken with nothing new
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         rsp_kind_ff  <= result.kind;
         rsp_byte_ff  <= result.data;
         rsp_index_ff <= result.index;
         rsp_last_ff  <= result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
